// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/qti_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qti_pkg
// Types, widths and helper functions of the quintic trajectory interpolator.
// ---------------------------------------------------------------------------
package qti_pkg;

	localparam int ACC_W   = 64;
	localparam int MUL_B_W = 24;
	localparam int DEN_W   = 40;
	localparam int COEF_W  = 32;
	localparam int SEG_W   = 20;
	localparam int ELAP_W  = 21;
	localparam int TICK_W  = 10;
	localparam int NCOEF   = 6;
	localparam int OUT_AXES = 3;

	localparam logic [MUL_B_W-1:0] MS_PER_S   = MUL_B_W'(1000);
	localparam logic [MUL_B_W-1:0] US_PER_S2  = MUL_B_W'(1000000);
	localparam logic [TICK_W-1:0]  TICK_RESET = TICK_W'(10);

	typedef enum logic [1:0] {
		FN_LOAD   = 2'd0,
		FN_START  = 2'd1,
		FN_TICK   = 2'd2,
		FN_CANCEL = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_RUN  = 2'd1,
		MODE_FIN  = 2'd2,
		MODE_ERR  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		POLY_POS = 2'd0,
		POLY_VEL = 2'd1,
		POLY_ACC = 2'd2
	} poly_t;

	// Factor that the k-th coefficient carries in P, P' or P''.
	function automatic logic [4:0] coef_weight(input poly_t pk, input logic [2:0] k);
		logic [4:0] w;
		w = 5'd0;
		case (pk)
			POLY_POS: w = 5'd1;
			POLY_VEL: w = 5'(k);
			default: begin
				case (k)
					3'd2: w = 5'd2;
					3'd3: w = 5'd6;
					3'd4: w = 5'd12;
					3'd5: w = 5'd20;
					default: w = 5'd0;
				endcase
			end
		endcase
		return w;
	endfunction

	// Lowest power of u that a polynomial uses.
	function automatic logic [2:0] poly_kmin(input poly_t pk);
		return 3'(pk);
	endfunction

	// Saturate a signed accumulator to 32 bits.
	function automatic logic [31:0] sat_signed(input logic signed [ACC_W-1:0] v);
		logic [31:0] r;
		if (v > ACC_W'(64'sd2147483647)) begin
			r = 32'h7fff_ffff;
		end else if (v < -ACC_W'(64'sd2147483648)) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Saturate a magnitude with a separate sign to 32 bits.
	function automatic logic [31:0] sat_mag(input logic [ACC_W-1:0] q, input logic neg);
		logic [31:0] r;
		if (neg) begin
			if (q > ACC_W'(64'h8000_0000)) begin
				r = 32'h8000_0000;
			end else begin
				r = ~q[31:0] + 32'd1;
			end
		end else begin
			if (q > ACC_W'(64'h7fff_ffff)) begin
				r = 32'h7fff_ffff;
			end else begin
				r = q[31:0];
			end
		end
		return r;
	endfunction

endpackage

// File: rtl/core/quintic_trajectory_interpolator.sv
`timescale 1ns / 1ps
// Timing: load, start and cancel beats present their result in the cycle after accept.
// A tick first divides for u on the radix-2 divider, then per evaluated axis runs
// the Horner steps on the bit-serial multiplier and, for velocity and acceleration,
// a scaling multiply on the same multiplier followed by a divide.
// Throughput: one item at a time; the next is accepted once the result is taken.
// Reset: async, active low; coefficients read as zero until loaded, period 10 ms.
// ---------------------------------------------------------------------------
// quintic_trajectory_interpolator
// Evaluates position, velocity and acceleration of quintic segments per axis
// with a shared serial multiplier and divider under a small sequencer.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module quintic_trajectory_interpolator #(
	parameter int AXES      = 3,
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// axis[1:0], coef_index[4:2], coef_value[36:5], duration_ms[56:37], zero fill
	input  logic [63:0]  s_tdata,
	// func[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z, 32 bits each
	output logic [287:0] m_tdata,
	// status[1:0], done_res[2], rejected[3]
	output logic [3:0]   m_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [9:0]   cfg_data
);
	import qti_pkg::*;

	localparam int DEPTH     = AXES * NCOEF;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int EVAL_AXES = (AXES < OUT_AXES) ? AXES : OUT_AXES;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIVU, ST_RDC, ST_LDC, ST_MULW, ST_POST, ST_SCL, ST_DIVS, ST_FIN, ST_OUT
	} state_t;

	state_t                     state_q;
	mode_t                      mode_q;
	logic [SEG_W-1:0]           seg_q;
	logic [DEN_W-1:0]           segsq_q;
	logic [ELAP_W-1:0]          elapsed_q;
	logic [TICK_W-1:0]          tick_q;
	logic [FRAC_BITS-1:0]       u_q;
	logic [1:0]                 ax_q;
	poly_t                      pk_q;
	logic [2:0]                 k_q;
	logic [ADDR_W-1:0]          addr_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic                       neg_q;
	logic [31:0]                pos_q   [OUT_AXES];
	logic [31:0]                vel_q   [OUT_AXES];
	logic [31:0]                accel_q [OUT_AXES];
	logic                       done_q;
	logic                       rej_q;
	logic                       mul_start_q;
	logic signed [ACC_W-1:0]    mul_a_q;
	logic [MUL_B_W-1:0]         mul_b_q;
	logic                       div_start_q;
	logic [ACC_W-1:0]           div_num_q;
	logic [DEN_W-1:0]           div_den_q;

	logic [COEF_W-1:0]          mem [DEPTH];
	logic [DEPTH-1:0]           vld_q;
	logic [COEF_W-1:0]          rdw_q;
	logic                       rdv_q;

	logic signed [ACC_W-1:0]    mul_p;
	logic                       mul_busy;
	logic                       mul_done;
	logic [ACC_W-1:0]           div_q;
	logic                       div_done;

	func_t                      in_func;
	logic [1:0]                 in_axis;
	logic [2:0]                 in_idx;
	logic [COEF_W-1:0]          in_coef;
	logic [SEG_W-1:0]           in_dur;
	logic                       accept;
	logic                       mem_we;
	logic [ADDR_W-1:0]          mem_wa;
	logic signed [COEF_W-1:0]   coef;
	logic signed [COEF_W+5:0]   scaled_n;
	logic signed [ACC_W-1:0]    scaled;
	logic signed [ACC_W-1:0]    horner;
	logic [ACC_W-1:0]           mag;
	logic [ELAP_W-1:0]          elapsed_n;
	logic [TICK_W-1:0]          step;

	function automatic logic [ADDR_W-1:0] caddr(input logic [1:0] a, input logic [2:0] k);
		logic [7:0] f;
		f = 8'(a) * 8'(NCOEF) + 8'(k);
		return f[ADDR_W-1:0];
	endfunction

	qti_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.p      (mul_p),
		.busy   (mul_busy),
		.done   (mul_done)
	);

	qti_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (div_num_q),
		.den    (div_den_q),
		.q      (div_q),
		.done   (div_done)
	);

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = (state_q == ST_OUT);
	assign m_tdata   = {accel_q[2], accel_q[1], accel_q[0], vel_q[2], vel_q[1], vel_q[0],
		pos_q[2], pos_q[1], pos_q[0]};
	assign m_tuser   = {rej_q, done_q, mode_q};

	always_comb begin
		in_func   = func_t'(s_tuser);
		in_axis   = s_tdata[1:0];
		in_idx    = s_tdata[4:2];
		in_coef   = s_tdata[36:5];
		in_dur    = s_tdata[56:37];
		accept    = s_tvalid && s_tready;
		mem_we    = accept && (in_func == FN_LOAD) && (mode_q != MODE_RUN) &&
			(32'(in_axis) < AXES) && (32'(in_idx) < NCOEF);
		mem_wa    = caddr(in_axis, in_idx);
		coef      = rdv_q ? $signed(rdw_q) : '0;
		scaled_n  = coef * $signed({1'b0, coef_weight(pk_q, k_q)});
		scaled    = ACC_W'(scaled_n);
		horner    = (mul_p >>> FRAC_BITS) + scaled;
		mag       = mul_p[ACC_W-1] ? ACC_W'(-mul_p) : ACC_W'(mul_p);
		step      = (tick_q == '0) ? TICK_W'(1) : tick_q;
		elapsed_n = elapsed_q + ELAP_W'(step);
	end

	// Coefficient store with registered read; entries never loaded read as zero.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= in_coef;
		end
		rdw_q <= mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rdv_q <= 1'b0;
		end else begin
			if (mem_we) begin
				vld_q[mem_wa] <= 1'b1;
			end
			rdv_q <= vld_q[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= TICK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tick_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_IDLE;
			seg_q       <= '0;
			segsq_q     <= '0;
			elapsed_q   <= '0;
			u_q         <= '0;
			ax_q        <= '0;
			pk_q        <= POLY_POS;
			k_q         <= '0;
			addr_q      <= '0;
			acc_q       <= '0;
			neg_q       <= 1'b0;
			done_q      <= 1'b0;
			rej_q       <= 1'b0;
			mul_start_q <= 1'b0;
			mul_a_q     <= '0;
			mul_b_q     <= '0;
			div_start_q <= 1'b0;
			div_num_q   <= '0;
			div_den_q   <= '0;
			for (int i = 0; i < OUT_AXES; i++) begin
				pos_q[i]   <= '0;
				vel_q[i]   <= '0;
				accel_q[i] <= '0;
			end
		end else begin
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						done_q <= 1'b0;
						rej_q  <= 1'b0;
						for (int i = 0; i < OUT_AXES; i++) begin
							pos_q[i]   <= '0;
							vel_q[i]   <= '0;
							accel_q[i] <= '0;
						end
						state_q <= ST_OUT;
						unique case (in_func)
							FN_LOAD: begin
								rej_q <= (mode_q == MODE_RUN);
							end
							FN_START: begin
								if (mode_q == MODE_RUN) begin
									rej_q <= 1'b1;
								end else begin
									seg_q     <= in_dur;
									segsq_q   <= DEN_W'(in_dur) * DEN_W'(in_dur);
									elapsed_q <= '0;
									if (in_dur == '0) begin
										mode_q <= MODE_FIN;
										done_q <= 1'b1;
									end else begin
										mode_q <= MODE_RUN;
									end
								end
							end
							FN_TICK: begin
								if (mode_q != MODE_RUN || seg_q == '0) begin
									rej_q <= 1'b1;
								end else begin
									div_num_q   <= ACC_W'(elapsed_q) << FRAC_BITS;
									div_den_q   <= DEN_W'(seg_q);
									div_start_q <= 1'b1;
									state_q     <= ST_DIVU;
								end
							end
							FN_CANCEL: begin
								if (mode_q != MODE_RUN) begin
									rej_q <= 1'b1;
								end else begin
									mode_q <= MODE_ERR;
									done_q <= 1'b1;
								end
							end
							default: begin
								rej_q <= 1'b1;
							end
						endcase
					end
				end
				ST_DIVU: begin
					if (div_done) begin
						u_q     <= div_q[FRAC_BITS-1:0];
						ax_q    <= '0;
						pk_q    <= POLY_POS;
						k_q     <= 3'd5;
						addr_q  <= caddr(2'd0, 3'd5);
						state_q <= ST_RDC;
					end
				end
				ST_RDC: begin
					state_q <= ST_LDC;
				end
				ST_LDC: begin
					acc_q <= scaled;
					if (k_q == poly_kmin(pk_q)) begin
						state_q <= ST_POST;
					end else begin
						k_q         <= k_q - 3'd1;
						addr_q      <= caddr(ax_q, k_q - 3'd1);
						mul_a_q     <= scaled;
						mul_b_q     <= MUL_B_W'(u_q);
						mul_start_q <= 1'b1;
						state_q     <= ST_MULW;
					end
				end
				ST_MULW: begin
					if (mul_done) begin
						acc_q <= horner;
						if (k_q == poly_kmin(pk_q)) begin
							state_q <= ST_POST;
						end else begin
							k_q         <= k_q - 3'd1;
							addr_q      <= caddr(ax_q, k_q - 3'd1);
							mul_a_q     <= horner;
							mul_b_q     <= MUL_B_W'(u_q);
							mul_start_q <= 1'b1;
						end
					end
				end
				ST_POST: begin
					if (pk_q == POLY_POS) begin
						pos_q[ax_q] <= sat_signed(acc_q);
						pk_q        <= POLY_VEL;
						k_q         <= 3'd5;
						addr_q      <= caddr(ax_q, 3'd5);
						state_q     <= ST_RDC;
					end else begin
						mul_a_q     <= acc_q;
						mul_b_q     <= (pk_q == POLY_VEL) ? MS_PER_S : US_PER_S2;
						mul_start_q <= 1'b1;
						state_q     <= ST_SCL;
					end
				end
				ST_SCL: begin
					if (mul_done) begin
						neg_q       <= mul_p[ACC_W-1];
						div_num_q   <= mag;
						div_den_q   <= (pk_q == POLY_VEL) ? DEN_W'(seg_q) : segsq_q;
						div_start_q <= 1'b1;
						state_q     <= ST_DIVS;
					end
				end
				ST_DIVS: begin
					if (div_done) begin
						k_q     <= 3'd5;
						state_q <= ST_RDC;
						if (pk_q == POLY_VEL) begin
							vel_q[ax_q] <= sat_mag(div_q, neg_q);
							pk_q        <= POLY_ACC;
							addr_q      <= caddr(ax_q, 3'd5);
						end else begin
							accel_q[ax_q] <= sat_mag(div_q, neg_q);
							pk_q          <= POLY_POS;
							if (ax_q == 2'(EVAL_AXES - 1)) begin
								state_q <= ST_FIN;
							end else begin
								ax_q   <= ax_q + 2'd1;
								addr_q <= caddr(ax_q + 2'd1, 3'd5);
							end
						end
					end
				end
				ST_FIN: begin
					elapsed_q <= elapsed_n;
					if (elapsed_n >= ELAP_W'(seg_q)) begin
						mode_q <= MODE_FIN;
						done_q <= 1'b1;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ASSERT_IMPL(a_u_below_one, state_q == ST_DIVU && div_done, div_q[ACC_W-1:FRAC_BITS] == '0, "normalized time is not below one")
	`ASSERT_IMPL(a_mul_free, mul_start_q, !mul_busy, "multiplier restarted while busy")
	`ASSERT_IMPL(a_done_mode, m_tvalid && done_q, mode_q == MODE_FIN || mode_q == MODE_ERR, "segment end reported without a final mode")
	`ASSERT_IMPL(a_rej_not_done, m_tvalid && rej_q, !done_q, "rejected beat also ends a segment")

endmodule

// File: rtl/core/qti_mul.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qti_mul
// Bit-serial shift-add multiplier: signed multiplicand times unsigned
// multiplier, one multiplier bit per cycle, product kept modulo 2^ACC_W.
// ---------------------------------------------------------------------------
module qti_mul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [qti_pkg::ACC_W-1:0]    a,
	input  logic        [qti_pkg::MUL_B_W-1:0]  b,
	output logic signed [qti_pkg::ACC_W-1:0]    p,
	output logic                                busy,
	output logic                                done
);
	import qti_pkg::*;

	localparam int CNT_W = $clog2(MUL_B_W + 1);

	logic [ACC_W-1:0]   mc_q;
	logic [MUL_B_W-1:0] mp_q;
	logic [ACC_W-1:0]   p_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mc_q   <= '0;
			mp_q   <= '0;
			p_q    <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			mc_q   <= a;
			mp_q   <= b;
			p_q    <= '0;
			cnt_q  <= CNT_W'(MUL_B_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			if (mp_q[0]) begin
				p_q <= p_q + mc_q;
			end
			mc_q   <= {mc_q[ACC_W-2:0], 1'b0};
			mp_q   <= {1'b0, mp_q[MUL_B_W-1:1]};
			cnt_q  <= cnt_q - CNT_W'(1);
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	assign p    = $signed(p_q);
	assign busy = (cnt_q != '0);
	assign done = done_q;

endmodule

// File: rtl/core/qti_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qti_div
// Radix-2 restoring divider: unsigned ACC_W-bit dividend by DEN_W-bit
// divisor, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module qti_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [qti_pkg::ACC_W-1:0]         num,
	input  logic [qti_pkg::DEN_W-1:0]         den,
	output logic [qti_pkg::ACC_W-1:0]         q,
	output logic                              done
);
	import qti_pkg::*;

	localparam int CNT_W = $clog2(ACC_W + 1);

	logic [ACC_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DEN_W:0]   rem_sh;
	logic [DEN_W:0]   rem_sub;
	logic             qbit;

	always_comb begin
		rem_sh  = {rem_q, num_q[ACC_W-1]};
		rem_sub = rem_sh - {1'b0, den_q};
		qbit    = (rem_sh >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q  <= '0;
			den_q  <= '0;
			rem_q  <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			cnt_q  <= CNT_W'(ACC_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			// The quotient bits shift in where the dividend bits leave.
			rem_q  <= qbit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			num_q  <= {num_q[ACC_W-2:0], qbit};
			cnt_q  <= cnt_q - CNT_W'(1);
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	assign q    = num_q;
	assign done = done_q;

endmodule

// File: dv/quintic_trajectory_interpolator_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quintic_trajectory_interpolator_tb
// Drives coefficient loads, segment starts, ticks and cancels through the
// input stream, predicts every result beat and compares it field by field.
// ---------------------------------------------------------------------------
module quintic_trajectory_interpolator_tb;
	import qti_pkg::*;

	typedef struct packed {
		func_t       func;
		logic [1:0]  axis;
		logic [2:0]  idx;
		logic [31:0] val;
		logic [19:0] dur;
	} beat_t;

	typedef struct {
		logic [31:0] motion [9];
		logic [1:0]  status;
		logic        done;
		logic        rej;
	} traj_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [63:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [287:0] m_tdata;
	logic [3:0] m_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [9:0] cfg_data = '0;

	quintic_trajectory_interpolator dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Predictor state.
	logic signed [31:0] coefs [3][6];
	logic [20:0] elapsed;
	logic [19:0] seg_len;
	mode_t mode;
	logic [9:0] period;

	beat_t pending [$];
	traj_res_t expected_res [$];
	int errors = 0;
	int accepted = 0;
	int cycles = 0;
	bit no_idle = 0;
	int hold_off = 0;
	int src_gap = 0;
	int snk_gap = 0;
	bit cfg_req = 0;
	logic [9:0] cfg_req_val;

	function automatic longint floor_q(longint x);
		return x >>> 16;
	endfunction

	function automatic logic [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'h7fff_ffff;
		if (v < -64'sd2147483648) return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic traj_res_t predict_traj(beat_t b);
		traj_res_t r;
		longint u, p, v, a, c [6];
		logic [9:0] stepv;
		for (int i = 0; i < 9; i++) r.motion[i] = '0;
		r.done = 0;
		r.rej = 0;
		case (b.func)
			FN_LOAD: begin
				if (mode == MODE_RUN) r.rej = 1;
				else if (b.axis < 3 && b.idx < 6) coefs[b.axis][b.idx] = b.val;
			end
			FN_START: begin
				if (mode == MODE_RUN) r.rej = 1;
				else begin
					seg_len = b.dur;
					elapsed = '0;
					if (b.dur == 0) begin
						mode = MODE_FIN;
						r.done = 1;
					end else mode = MODE_RUN;
				end
			end
			FN_TICK: begin
				if (mode != MODE_RUN || seg_len == 0) r.rej = 1;
				else begin
					u = (longint'(elapsed) << 16) / longint'(seg_len);
					for (int ax = 0; ax < 3; ax++) begin
						for (int k = 0; k < 6; k++) c[k] = longint'(coefs[ax][k]);
						p = c[5];
						for (int k = 4; k >= 0; k--) p = floor_q(p * u) + c[k];
						v = 5 * c[5];
						for (int k = 4; k >= 1; k--) v = floor_q(v * u) + k * c[k];
						a = 20 * c[5];
						a = floor_q(a * u) + 12 * c[4];
						a = floor_q(a * u) + 6 * c[3];
						a = floor_q(a * u) + 2 * c[2];
						r.motion[ax] = clamp32(p);
						r.motion[3 + ax] = clamp32((v * 1000) / longint'(seg_len));
						r.motion[6 + ax] = clamp32((a * 1000000) /
							(longint'(seg_len) * longint'(seg_len)));
					end
					stepv = (period == 0) ? 10'd1 : period;
					elapsed = elapsed + 21'(stepv);
					if (elapsed >= 21'(seg_len)) begin
						mode = MODE_FIN;
						r.done = 1;
					end
				end
			end
			default: begin
				if (mode != MODE_RUN) r.rej = 1;
				else begin
					mode = MODE_ERR;
					r.done = 1;
				end
			end
		endcase
		r.status = mode;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch on result %0d: %s got %h expected %h", accepted, what, got, want);
		errors++;
	endtask

	// Input driver.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_res.push_back(predict_traj(pending.pop_front()));
			end
			if (!(s_tvalid && !s_tready)) begin
				if (src_gap > 0) begin
					src_gap <= src_gap - 1;
					s_tvalid <= 1'b0;
				end else if (pending.size() > 0) begin
					if (!no_idle && $urandom_range(0, 9) == 0) begin
						src_gap <= $urandom_range(1, 7) - 1;
						s_tvalid <= 1'b0;
					end else begin
						s_tvalid <= 1'b1;
						s_tdata <= {7'd0, pending[0].dur, pending[0].val,
							pending[0].idx, pending[0].axis};
						s_tuser <= pending[0].func;
					end
				end else s_tvalid <= 1'b0;
			end
		end
	end

	// Result monitor and receiver stalls.
	always @(posedge clk) begin
		traj_res_t e;
		if (arst_n) begin
			cycles <= cycles + 1;
			if (m_tvalid && m_tready) begin
				accepted <= accepted + 1;
				if (expected_res.size() == 0) begin
					report_mismatch("unexpected result beat", 32'(m_tuser), 32'd0);
				end else begin
					e = expected_res.pop_front();
					for (int i = 0; i < 9; i++)
						if (m_tdata[32*i +: 32] !== e.motion[i])
							report_mismatch($sformatf("motion word %0d", i),
								m_tdata[32*i +: 32], e.motion[i]);
					if (m_tuser[1:0] !== e.status)
						report_mismatch("status", 32'(m_tuser[1:0]), 32'(e.status));
					if (m_tuser[2] !== e.done)
						report_mismatch("done_res", 32'(m_tuser[2]), 32'(e.done));
					if (m_tuser[3] !== e.rej)
						report_mismatch("rejected", 32'(m_tuser[3]), 32'(e.rej));
				end
			end
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				m_tready <= 1'b0;
			end else if (snk_gap > 0) begin
				snk_gap <= snk_gap - 1;
				m_tready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 9) == 0) begin
				snk_gap <= $urandom_range(1, 7) - 1;
				m_tready <= 1'b0;
			end else m_tready <= 1'b1;
		end
	end

	// Configuration channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				period = cfg_data;
				cfg_valid <= 1'b0;
				cfg_req <= 0;
			end else if (cfg_req && !cfg_valid) begin
				cfg_valid <= 1'b1;
				cfg_data <= cfg_req_val;
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > 20000000) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic beat_t mk(func_t f, logic [1:0] ax, logic [2:0] k,
			logic [31:0] v, logic [19:0] d);
		beat_t b;
		b.func = f; b.axis = ax; b.idx = k; b.val = v; b.dur = d;
		return b;
	endfunction

	// A beat of the given function with every other field random.
	function automatic beat_t rnd_beat(func_t f);
		return mk(f, 2'($urandom), 3'($urandom), $urandom, 20'($urandom));
	endfunction

	function automatic logic [31:0] rnd_coef();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 32'h0003_ffff) - 32'h0002_0000;
			2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
			default: return $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
		endcase
	endfunction

	task automatic drain();
		while (pending.size() > 0 || s_tvalid || expected_res.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_period(logic [9:0] p);
		cfg_req_val = p;
		cfg_req = 1;
		while (cfg_req) @(posedge clk);
	endtask

	// A segment: load coefficients, start, then mostly ticks with some cancels, loads and starts mixed in.
	task automatic queue_segment(int nticks);
		logic [19:0] d;
		beat_t b;
		int nloads;
		nloads = $urandom_range(1, 8);
		for (int i = 0; i < nloads; i++) begin
			b = rnd_beat(FN_LOAD);
			b.axis = 2'($urandom_range(0, 3));
			b.idx = 3'($urandom_range(0, 7));
			b.val = rnd_coef();
			pending.push_back(b);
		end
		d = ($urandom_range(0, 19) == 0) ? 20'($urandom) : 20'($urandom_range(1, 400));
		b = rnd_beat(FN_START);
		b.dur = d;
		pending.push_back(b);
		for (int i = 0; i < nticks; i++) begin
			case ($urandom_range(0, 19))
				0: pending.push_back(rnd_beat(FN_CANCEL));
				1: pending.push_back(rnd_beat(FN_LOAD));
				2: pending.push_back(rnd_beat(FN_START));
				default: pending.push_back(rnd_beat(FN_TICK));
			endcase
		end
	endtask

	initial begin
		for (int a = 0; a < 3; a++) for (int k = 0; k < 6; k++) coefs[a][k] = '0;
		elapsed = '0; seg_len = '0; mode = MODE_IDLE; period = TICK_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset period, rejects while idle, extremes, zero duration.
		pending.push_back(mk(FN_TICK, 0, 0, 0, 0));
		pending.push_back(mk(FN_CANCEL, 0, 0, 0, 0));
		pending.push_back(mk(FN_LOAD, 0, 0, 32'h7fff_ffff, 0));
		pending.push_back(mk(FN_LOAD, 1, 5, 32'h8000_0000, 20'hfffff));
		pending.push_back(mk(FN_LOAD, 2, 3, 32'hffff_ffff, 0));
		pending.push_back(mk(FN_LOAD, 3, 2, 32'h1234_5678, 0));
		pending.push_back(mk(FN_LOAD, 0, 6, 32'h1234_5678, 0));
		pending.push_back(mk(FN_LOAD, 2, 7, 32'h5555_aaaa, 0));
		pending.push_back(mk(FN_LOAD, 0, 5, 32'h7fff_ffff, 0));
		pending.push_back(mk(FN_START, 0, 0, 0, 0));
		pending.push_back(mk(FN_TICK, 0, 0, 0, 0));
		pending.push_back(mk(FN_START, 0, 0, 0, 1));
		pending.push_back(mk(FN_LOAD, 0, 0, 0, 0));
		pending.push_back(mk(FN_START, 0, 0, 0, 25));
		pending.push_back(mk(FN_TICK, 0, 0, 0, 0));
		pending.push_back(mk(FN_CANCEL, 0, 0, 0, 0));
		pending.push_back(mk(FN_CANCEL, 0, 0, 0, 0));
		pending.push_back(mk(FN_START, 0, 0, 0, 20'hfffff));
		pending.push_back(mk(FN_TICK, 0, 0, 0, 0));
		pending.push_back(mk(FN_TICK, 0, 0, 0, 0));
		pending.push_back(mk(FN_CANCEL, 0, 0, 0, 0));
		drain();

		set_period(0);
		pending.push_back(mk(FN_START, 0, 0, 0, 2));
		pending.push_back(mk(FN_TICK, 0, 0, 0, 0));
		pending.push_back(mk(FN_TICK, 0, 0, 0, 0));
		drain();
		set_period(10'd1000);
		pending.push_back(mk(FN_START, 0, 0, 0, 1500));
		pending.push_back(mk(FN_TICK, 0, 0, 0, 0));
		pending.push_back(mk(FN_TICK, 0, 0, 0, 0));
		drain();

		// Long receiver stall while the sender keeps offering beats.
		hold_off = 300;
		queue_segment(6);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_period(10'd1);
				1: set_period(10'd1023);
				5: set_period(10'd10);
				default: set_period(10'($urandom_range(1, 1000)));
			endcase
			if (ph == 5) no_idle = 1;
			while (pending.size() < 200) queue_segment($urandom_range(1, 12));
			drain();
		end

		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
